>>> src/mbe_pkg.sv
// ----------------------------------------------------------------------------
// mbe_pkg: shared types and constants for the escape-time unit
// fixed-point format, register indexes, configuration bundle, saturation
// ----------------------------------------------------------------------------
package mbe_pkg;

    localparam int FRAC_BITS  = 28;
    localparam int WORD_W     = 32;
    localparam int PROD_W     = 2 * WORD_W;
    localparam int COORD_W    = 12;
    localparam int DIM_W      = 13;
    localparam int COUNT_W    = 12;
    localparam int INDEX_W    = 24;
    localparam int CFG_IDX_W  = 3;

    localparam logic [DIM_W-1:0]  MAX_DIM = 13'd4096;
    localparam logic [PROD_W-1:0] ESCAPE_THRESH = 64'd4 << (2 * FRAC_BITS);

    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_RE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_IM    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_RE      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_IM      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd6;

    localparam logic signed [WORD_W-1:0] RST_ORIGIN_RE = -32'sd536870912;
    localparam logic signed [WORD_W-1:0] RST_ORIGIN_IM = -32'sd402653184;
    localparam logic signed [WORD_W-1:0] RST_STEP      = 32'sd196657;
    localparam logic [COUNT_W-1:0]       RST_MAX_ITER  = 12'd1000;
    localparam logic [DIM_W-1:0]         RST_DIM       = 13'd4096;

    typedef struct packed {
        logic signed [WORD_W-1:0] origin_re;
        logic signed [WORD_W-1:0] origin_im;
        logic signed [WORD_W-1:0] step_re;
        logic signed [WORD_W-1:0] step_im;
        logic [COUNT_W-1:0]       limit;
        logic [DIM_W-1:0]         width;
        logic [DIM_W-1:0]         height;
    } cfg_t;

    function automatic logic signed [WORD_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
        logic signed [WORD_W-1:0] r;
        if (v > 64'sd2147483647)
        begin
            r = 32'sh7fffffff;
        end
        else if (v < -64'sd2147483648)
        begin
            r = 32'sh80000000;
        end
        else
        begin
            r = signed'(v[WORD_W-1:0]);
        end
        return r;
    endfunction

endpackage

>>> src/mbe_mult.sv
// ----------------------------------------------------------------------------
// mbe_mult: shared signed multiplier
// one 32x32 signed product per cycle, result registered
// ----------------------------------------------------------------------------
module mbe_mult
    import mbe_pkg::*;
(
    input  logic                      clk,
    input  logic signed [WORD_W-1:0]  a,
    input  logic signed [WORD_W-1:0]  b,
    output logic signed [PROD_W-1:0]  prod
);

    logic signed [PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(a) * PROD_W'(b);
    end

    assign prod = prod_reg;

endmodule

>>> src/mbe_cfg.sv
// ----------------------------------------------------------------------------
// mbe_cfg: configuration registers
// register writes by index, clamped view handed to the core
// ----------------------------------------------------------------------------
module mbe_cfg
    import mbe_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [WORD_W-1:0]     cfg_data,
    output cfg_t                  cfg
);

    logic signed [WORD_W-1:0] origin_re_reg;
    logic signed [WORD_W-1:0] origin_im_reg;
    logic signed [WORD_W-1:0] step_re_reg;
    logic signed [WORD_W-1:0] step_im_reg;
    logic [COUNT_W-1:0]       max_iter_reg;
    logic [DIM_W-1:0]         width_reg;
    logic [DIM_W-1:0]         height_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_re_reg <= RST_ORIGIN_RE;
            origin_im_reg <= RST_ORIGIN_IM;
            step_re_reg   <= RST_STEP;
            step_im_reg   <= RST_STEP;
            max_iter_reg  <= RST_MAX_ITER;
            width_reg     <= RST_DIM;
            height_reg    <= RST_DIM;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_ORIGIN_RE:    origin_re_reg <= signed'(cfg_data);
                REG_ORIGIN_IM:    origin_im_reg <= signed'(cfg_data);
                REG_STEP_RE:      step_re_reg   <= signed'(cfg_data);
                REG_STEP_IM:      step_im_reg   <= signed'(cfg_data);
                REG_MAX_ITER:     max_iter_reg  <= cfg_data[COUNT_W-1:0];
                REG_IMAGE_WIDTH:  width_reg     <= cfg_data[DIM_W-1:0];
                REG_IMAGE_HEIGHT: height_reg    <= cfg_data[DIM_W-1:0];
                default:          ;
            endcase
        end
    end

    // dimensions above the supported size act as the supported size
    always_comb
    begin
        cfg.origin_re = origin_re_reg;
        cfg.origin_im = origin_im_reg;
        cfg.step_re   = step_re_reg;
        cfg.step_im   = step_im_reg;
        cfg.limit     = max_iter_reg;
        cfg.width     = (width_reg > MAX_DIM) ? MAX_DIM : width_reg;
        cfg.height    = (height_reg > MAX_DIM) ? MAX_DIM : height_reg;
    end

endmodule

>>> src/mbe_core.sv
// ----------------------------------------------------------------------------
// mbe_core: escape-time sequencer and datapath
// drives the shared multiplier through setup and iteration steps
// ----------------------------------------------------------------------------
module mbe_core
    import mbe_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cfg_t                  cfg,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [COORD_W-1:0]    col,
    input  logic [COORD_W-1:0]    row,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [INDEX_W-1:0]    pixel_index,
    output logic [COUNT_W-1:0]    iteration_count
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_C_RE,
        ST_C_IM,
        ST_C_IDX,
        ST_C_PIX,
        ST_XX,
        ST_YY,
        ST_XY,
        ST_UPD,
        ST_DONE
    } state_t;

    state_t                   state_reg, state_next;
    logic [COORD_W-1:0]       col_reg, col_next;
    logic [COORD_W-1:0]       row_reg, row_next;
    logic signed [WORD_W-1:0] cx_reg, cx_next;
    logic signed [WORD_W-1:0] cy_reg, cy_next;
    logic signed [WORD_W-1:0] zx_reg, zx_next;
    logic signed [WORD_W-1:0] zy_reg, zy_next;
    logic signed [PROD_W-1:0] xx_reg, xx_next;
    logic signed [PROD_W-1:0] diff_reg, diff_next;
    logic [COUNT_W-1:0]       it_reg, it_next;
    logic [COUNT_W-1:0]       count_reg, count_next;
    logic                     check_reg, check_next;
    logic [INDEX_W-1:0]       pix_reg, pix_next;
    logic                     out_valid_reg, out_valid_next;
    logic [INDEX_W-1:0]       out_pix_reg, out_pix_next;
    logic [COUNT_W-1:0]       out_cnt_reg, out_cnt_next;

    logic signed [WORD_W-1:0] mul_a;
    logic signed [WORD_W-1:0] mul_b;
    logic signed [PROD_W-1:0] prod;
    logic [PROD_W-1:0]        mag;
    logic                     in_range;

    mbe_mult u_mult (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    assign in_ready        = (state_reg == ST_IDLE);
    assign out_valid       = out_valid_reg;
    assign pixel_index     = out_pix_reg;
    assign iteration_count = out_cnt_reg;

    assign in_range = ({1'b0, col} < cfg.width) && ({1'b0, row} < cfg.height);
    assign mag      = unsigned'(xx_reg) + unsigned'(prod);

    // operand select for the shared multiplier
    always_comb
    begin
        case (state_reg)
            ST_C_RE:
            begin
                mul_a = cfg.step_re;
                mul_b = signed'(WORD_W'(col_reg));
            end
            ST_C_IM:
            begin
                mul_a = cfg.step_im;
                mul_b = signed'(WORD_W'(row_reg));
            end
            ST_C_IDX:
            begin
                mul_a = signed'(WORD_W'(cfg.width));
                mul_b = signed'(WORD_W'(row_reg));
            end
            ST_XX:
            begin
                mul_a = zx_reg;
                mul_b = zx_reg;
            end
            ST_YY:
            begin
                mul_a = zy_reg;
                mul_b = zy_reg;
            end
            ST_XY:
            begin
                mul_a = zx_reg;
                mul_b = zy_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        zx_next        = zx_reg;
        zy_next        = zy_reg;
        xx_next        = xx_reg;
        diff_next      = diff_reg;
        it_next        = it_reg;
        count_next     = count_reg;
        check_next     = check_reg;
        pix_next       = pix_reg;
        out_pix_next   = out_pix_reg;
        out_cnt_next   = out_cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    col_next = col;
                    row_next = row;
                    // pixels outside the image are dropped
                    if (in_range)
                    begin
                        state_next = ST_C_RE;
                    end
                end
            end
            ST_C_RE:
            begin
                state_next = ST_C_IM;
            end
            ST_C_IM:
            begin
                cx_next    = sat32(PROD_W'(cfg.origin_re) + prod);
                zx_next    = cx_next;
                state_next = ST_C_IDX;
            end
            ST_C_IDX:
            begin
                cy_next    = sat32(PROD_W'(cfg.origin_im) + prod);
                zy_next    = cy_next;
                state_next = ST_C_PIX;
            end
            ST_C_PIX:
            begin
                pix_next   = INDEX_W'(col_reg) + prod[INDEX_W-1:0];
                it_next    = '0;
                check_next = 1'b0;
                if (cfg.limit == '0)
                begin
                    count_next = '0;
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_XX;
                end
            end
            ST_XX:
            begin
                state_next = ST_YY;
            end
            ST_YY:
            begin
                xx_next    = prod;
                state_next = ST_XY;
            end
            ST_XY:
            begin
                // prod holds zy^2 here, xx_reg holds zx^2
                diff_next = xx_reg - prod;
                if (check_reg && (mag > ESCAPE_THRESH))
                begin
                    count_next = it_reg;
                    state_next = ST_DONE;
                end
                else if (check_reg && ((it_reg + 1'b1) == cfg.limit))
                begin
                    count_next = cfg.limit;
                    state_next = ST_DONE;
                end
                else
                begin
                    if (check_reg)
                    begin
                        it_next = it_reg + 1'b1;
                    end
                    state_next = ST_UPD;
                end
            end
            ST_UPD:
            begin
                zx_next    = sat32((diff_reg >>> FRAC_BITS) + PROD_W'(cx_reg));
                zy_next    = sat32((prod >>> (FRAC_BITS - 1)) + PROD_W'(cy_reg));
                check_next = 1'b1;
                state_next = ST_XX;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_pix_next   = pix_reg;
                    out_cnt_next   = count_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            col_reg       <= '0;
            row_reg       <= '0;
            cx_reg        <= '0;
            cy_reg        <= '0;
            zx_reg        <= '0;
            zy_reg        <= '0;
            xx_reg        <= '0;
            diff_reg      <= '0;
            it_reg        <= '0;
            count_reg     <= '0;
            check_reg     <= 1'b0;
            pix_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_pix_reg   <= '0;
            out_cnt_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            cx_reg        <= cx_next;
            cy_reg        <= cy_next;
            zx_reg        <= zx_next;
            zy_reg        <= zy_next;
            xx_reg        <= xx_next;
            diff_reg      <= diff_next;
            it_reg        <= it_next;
            count_reg     <= count_next;
            check_reg     <= check_next;
            pix_reg       <= pix_next;
            out_valid_reg <= out_valid_next;
            out_pix_reg   <= out_pix_next;
            out_cnt_reg   <= out_cnt_next;
        end
    end

endmodule

>>> src/mandelbrot_escape_time.sv
// ----------------------------------------------------------------------------
// mandelbrot_escape_time: escape-time count for one pixel per request
// Each request carries a pixel column and row. Pixels outside the configured
// image are consumed without a result. For a pixel inside, c is formed in
// signed Q4.28 from the corner and step registers, z starts at c and
// z = z*z + c is iterated until |z|^2 exceeds 4 or max_iter is reached; the
// result carries the linear pixel index and the count. One pixel at a time:
// a single 32x32 multiplier is shared by every product. After a request is
// accepted come the setup steps that form c and the pixel index, the first
// update of z from c, each further iteration (three products and an update),
// and the last escape check and the handoff. The input is not ready while a
// pixel is in progress; a finished result waits in its own register so the
// next request can start, and the handoff stalls while that register is full.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time
    import mbe_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [WORD_W-1:0]     cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [COORD_W-1:0]    col,
    input  logic [COORD_W-1:0]    row,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [INDEX_W-1:0]    pixel_index,
    output logic [COUNT_W-1:0]    iteration_count
);

    cfg_t cfg;

    mbe_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    mbe_core u_core (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .col             (col),
        .row             (row),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .pixel_index     (pixel_index),
        .iteration_count (iteration_count)
    );

endmodule

>>> tb/tb_mandelbrot_escape_time.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_mandelbrot_escape_time: self-checking bench for the escape-time unit
// A driver and a monitor run as clocked processes around the pixel unit. Each
// accepted pixel request is run through a fixed-point escape-time predictor
// that keeps its own copy of the view registers, and every result is checked
// in order against it. Directed corner cases come first, then randomized
// views and pixels under changing back-pressure, with a long output stall.
// ----------------------------------------------------------------------------
module tb_mandelbrot_escape_time
    import mbe_pkg::*;
;

    localparam int     CYCLE_LIMIT = 3000000;
    localparam int     SETTLE      = 64;
    localparam int     MAX_REPORTS = 200;
    localparam longint WORD_MAX    = 64'sd2147483647;
    localparam longint WORD_MIN    = -64'sd2147483648;

    typedef struct packed {
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
    } pixel_req_t;

    typedef struct packed {
        logic [INDEX_W-1:0] pixel_index;
        logic [COUNT_W-1:0] count;
    } pixel_result_t;

    logic                 clk;
    logic                 rst_n           = 1'b0;
    logic                 cfg_valid       = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index       = '0;
    logic [WORD_W-1:0]    cfg_data        = '0;
    logic                 in_valid        = 1'b0;
    logic                 in_ready;
    logic [COORD_W-1:0]   col             = '0;
    logic [COORD_W-1:0]   row             = '0;
    logic                 out_valid;
    logic                 out_ready       = 1'b0;
    logic [INDEX_W-1:0]   pixel_index;
    logic [COUNT_W-1:0]   iteration_count;

    cfg_t          view;
    pixel_req_t    pending_pixels[$];
    pixel_result_t expected_counts[$];
    pixel_req_t    next_req;
    pixel_result_t predicted;
    pixel_result_t oldest;

    int   send_idle_pct = 16;
    int   recv_idle_pct = 79;
    logic out_hold      = 1'b0;
    int   n_accepted    = 0;
    int   n_errors      = 0;
    int   cycle_cnt     = 0;

    mandelbrot_escape_time i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .col             (col),
        .row             (row),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .pixel_index     (pixel_index),
        .iteration_count (iteration_count)
    );

    function automatic longint clip_word(input longint v);
        longint r;
        if (v > WORD_MAX)
        begin
            r = WORD_MAX;
        end
        else if (v < WORD_MIN)
        begin
            r = WORD_MIN;
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

    // returns 0 for a pixel outside the image
    function automatic bit escape_count(input logic [COORD_W-1:0] px,
                                        input logic [COORD_W-1:0] py,
                                        output pixel_result_t res);
        longint     w;
        longint     h;
        longint     lim;
        longint     cx;
        longint     cy;
        longint     zx;
        longint     zy;
        longint     nx;
        longint     ny;
        logic [63:0] mag;
        int         it;
        bit         escaped;
        w   = (view.width > MAX_DIM) ? longint'(MAX_DIM) : longint'(view.width);
        h   = (view.height > MAX_DIM) ? longint'(MAX_DIM) : longint'(view.height);
        lim = longint'(view.limit);
        res = '0;
        if (longint'(px) >= w || longint'(py) >= h)
        begin
            return 1'b0;
        end
        cx = clip_word(longint'($signed(view.origin_re))
                       + longint'($signed(view.step_re)) * longint'(px));
        cy = clip_word(longint'($signed(view.origin_im))
                       + longint'($signed(view.step_im)) * longint'(py));
        zx = cx;
        zy = cy;
        it = 0;
        escaped = 1'b0;
        while (it < lim && !escaped)
        begin
            nx = clip_word(((zx * zx - zy * zy) >>> FRAC_BITS) + cx);
            ny = clip_word(((zx * zy) >>> (FRAC_BITS - 1)) + cy);
            zx = nx;
            zy = ny;
            mag = zx * zx + zy * zy;
            if (mag > ESCAPE_THRESH)
            begin
                escaped = 1'b1;
            end
            else
            begin
                it++;
            end
        end
        res.pixel_index = INDEX_W'(longint'(px) + longint'(py) * w);
        res.count       = COUNT_W'(it);
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what);
        if (n_errors < MAX_REPORTS)
        begin
            $display("mismatch @%0t: %s", $realtime, what);
        end
        n_errors++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_ORIGIN_RE:    view.origin_re = data;
            REG_ORIGIN_IM:    view.origin_im = data;
            REG_STEP_RE:      view.step_re   = data;
            REG_STEP_IM:      view.step_im   = data;
            REG_MAX_ITER:     view.limit     = data[COUNT_W-1:0];
            REG_IMAGE_WIDTH:  view.width     = data[DIM_W-1:0];
            REG_IMAGE_HEIGHT: view.height    = data[DIM_W-1:0];
            default: ;
        endcase
    endtask

    // unused upper bits of the narrow registers carry random junk
    task automatic set_view(input logic [31:0] o_re, input logic [31:0] o_im,
                            input logic [31:0] s_re, input logic [31:0] s_im,
                            input logic [31:0] lim, input logic [31:0] w,
                            input logic [31:0] h);
        write_reg(REG_ORIGIN_RE, o_re);
        write_reg(REG_ORIGIN_IM, o_im);
        write_reg(REG_STEP_RE, s_re);
        write_reg(REG_STEP_IM, s_im);
        write_reg(REG_MAX_ITER, ($urandom() & ~32'h0fff) | lim);
        write_reg(REG_IMAGE_WIDTH, ($urandom() & ~32'h1fff) | w);
        write_reg(REG_IMAGE_HEIGHT, ($urandom() & ~32'h1fff) | h);
    endtask

    task automatic queue_pixel(input int c, input int r);
        pixel_req_t req;
        req.col = COORD_W'(c);
        req.row = COORD_W'(r);
        pending_pixels.push_back(req);
    endtask

    // out-of-range pixels leave no result, so give the block time to finish
    task automatic drain;
        @(negedge clk);
        while (pending_pixels.size() != 0 || in_valid)
            @(negedge clk);
        while (expected_counts.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // request driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                n_accepted <= n_accepted + 1;
                if (escape_count(col, row, predicted))
                begin
                    expected_counts.push_back(predicted);
                end
            end
            if (!in_valid || in_ready)
            begin
                if (pending_pixels.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    next_req = pending_pixels.pop_front();
                    in_valid <= 1'b1;
                    col      <= next_req.col;
                    row      <= next_req.row;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_counts.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result, pixel %0d count %0d",
                                              pixel_index, iteration_count));
                end
                else
                begin
                    oldest = expected_counts.pop_front();
                    if (pixel_index !== oldest.pixel_index)
                    begin
                        report_mismatch($sformatf("pixel_index got %0d want %0d",
                                                  pixel_index, oldest.pixel_index));
                    end
                    if (iteration_count !== oldest.count)
                    begin
                        report_mismatch($sformatf("iteration_count got %0d want %0d (pixel %0d)",
                                                  iteration_count, oldest.count,
                                                  oldest.pixel_index));
                    end
                end
            end
            out_ready <= !out_hold && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // long output stall while requests keep coming
    initial
    begin
        while (n_accepted < 40)
            @(posedge clk);
        out_hold <= 1'b1;
        repeat (3000) @(posedge clk);
        out_hold <= 1'b0;
    end

    initial
    begin
        int          ph;
        int          k;
        int          w;
        int          h;
        int          cmax;
        int          rmax;
        logic [31:0] o_re;
        logic [31:0] o_im;
        logic [31:0] s_re;
        logic [31:0] s_im;
        logic [31:0] lim;

        view.origin_re = RST_ORIGIN_RE;
        view.origin_im = RST_ORIGIN_IM;
        view.step_re   = RST_STEP;
        view.step_im   = RST_STEP;
        view.limit     = RST_MAX_ITER;
        view.width     = RST_DIM;
        view.height    = RST_DIM;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // reset view: image corners and two pixels inside the set
        queue_pixel(0, 0);
        queue_pixel(4095, 4095);
        queue_pixel(4095, 0);
        queue_pixel(0, 4095);
        queue_pixel(2731, 2048);
        queue_pixel(2048, 2048);
        drain();

        // zero width, oversized height: nothing comes back
        set_view(32'h0, 32'h0, 32'h0100_0000, 32'h0100_0000, 100, 0, 8191);
        queue_pixel(5, 5);
        queue_pixel(0, 0);
        drain();

        // zero iteration limit, one-row image with edges
        set_view(32'he000_0000, 32'hf000_0000, 32'h1000_0000, 32'h0800_0000, 0, 3, 1);
        queue_pixel(2, 0);
        queue_pixel(3, 0);
        queue_pixel(0, 1);
        queue_pixel(0, 0);
        drain();

        // saturating corner and step, clamped dimensions, full limit
        set_view(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 4095, 8191, 8191);
        queue_pixel(4095, 4095);
        queue_pixel(1, 1);
        queue_pixel(0, 0);
        drain();

        // bounded orbit running the full limit
        set_view(32'h0, 32'h0, 32'h1, 32'h1, 4095, 4096, 4096);
        queue_pixel(0, 0);
        queue_pixel(4095, 4095);
        drain();

        for (ph = 0; ph < 12; ph++)
        begin
            if (ph < 4)
            begin
                send_idle_pct <= 16;
                recv_idle_pct <= 79;
            end
            else if (ph < 8)
            begin
                send_idle_pct <= 79;
                recv_idle_pct <= 16;
            end
            else
            begin
                send_idle_pct <= 0;
                recv_idle_pct <= 0;
            end

            if ($urandom_range(7) == 0)
            begin
                o_re = $urandom();
                o_im = $urandom();
                s_re = $urandom();
                s_im = $urandom();
            end
            else
            begin
                o_re = $urandom_range(0, 32'h3000_0000) - 32'h2800_0000;
                o_im = $urandom_range(0, 32'h3000_0000) - 32'h1800_0000;
                s_re = $urandom_range(0, 32'h0100_0000);
                s_im = $urandom_range(0, 32'h0100_0000);
                if ($urandom_range(1))
                    s_re = -s_re;
                if ($urandom_range(1))
                    s_im = -s_im;
            end
            lim = ($urandom_range(15) == 0) ? 0 : $urandom_range(1, 48);
            case ($urandom_range(9))
                0: w = 8191;
                1: w = 4096;
                default: w = $urandom_range(1, 64);
            endcase
            case ($urandom_range(9))
                0: h = 8191;
                1: h = 4096;
                default: h = $urandom_range(1, 64);
            endcase
            set_view(o_re, o_im, s_re, s_im, lim, w, h);

            cmax = (w >= 4096) ? 4095 : w;
            rmax = (h >= 4096) ? 4095 : h;
            for (k = 0; k < 49; k++)
            begin
                if ($urandom_range(9) == 0)
                    queue_pixel($urandom_range(4095), $urandom_range(4095));
                else
                    queue_pixel($urandom_range(0, cmax), $urandom_range(0, rmax));
            end
            drain();
        end

        if (n_errors == 0 && expected_counts.size() == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
